// ===== sv/assert_macros.svh =====
// assertion helpers shared by the filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held; expects clk and rst_n in scope
`define BQC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define BQC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bqc_pkg.sv =====
// ----------------------------------------------------------------------------
// bqc_pkg
// Types and fixed constants of the cascaded biquad filter.
// ----------------------------------------------------------------------------
package bqc_pkg;

    localparam int GUARD_BITS    = 8;
    localparam int COEFS_PER_SEC = 6;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    // per-section sequence; coefficient k is read in phase k
    localparam logic [2:0] PH_READ = 3'd0;
    localparam logic [2:0] PH_B0   = 3'd1;
    localparam logic [2:0] PH_B1   = 3'd2;
    localparam logic [2:0] PH_B2   = 3'd3;
    localparam logic [2:0] PH_A1   = 3'd4;
    localparam logic [2:0] PH_A2   = 3'd5;
    localparam logic [2:0] PH_GAIN = 3'd6;
    localparam logic [2:0] PH_WB   = 3'd7;

    typedef struct packed {
        logic               cmd;
        logic [4:0]         channel;
        logic signed [15:0] sample_in;
        logic [4:0]         coef_slot;
        logic signed [31:0] coef_word;
    } in_item_t;

    typedef struct packed {
        logic [4:0]         out_channel;
        logic signed [15:0] filtered;
        logic               clipped;
    } out_item_t;

    typedef logic [2:0] cfg_word_t;

    typedef struct packed {
        logic               busy;
        logic [2:0]         phase;
    } mac_ctrl_t;

    typedef struct packed {
        logic signed [15:0] x1;
        logic signed [15:0] x2;
        logic signed [15:0] y1;
        logic signed [15:0] y2;
    } hist_word_t;

endpackage

// ===== sv/bqc_stream_if.sv =====
// ----------------------------------------------------------------------------
// bqc_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface bqc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/bqc_ram.sv =====
// ----------------------------------------------------------------------------
// bqc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bqc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 24
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== sv/bqc_mac.sv =====
// ----------------------------------------------------------------------------
// bqc_mac
// Shared multiplier and accumulators computing one biquad section output.
// ----------------------------------------------------------------------------
module bqc_mac #(
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                clk,
    input  bqc_pkg::mac_ctrl_t  ctrl,
    input  logic signed [31:0]  coef,
    input  bqc_pkg::hist_word_t hist,
    input  logic signed [15:0]  x_in,
    output logic signed [15:0]  y,
    output logic                clip
);
    localparam int FF_SHIFT = COEF_FRAC_BITS - bqc_pkg::GUARD_BITS;
    localparam int Y_SHIFT  = COEF_FRAC_BITS + bqc_pkg::GUARD_BITS;
    localparam int ACC_W    = 50;
    localparam int TOT_W    = 66;

    localparam logic signed [ACC_W:0]   FF_HALF = (ACC_W+1)'(1) <<< (FF_SHIFT - 1);
    localparam logic signed [ACC_W:0]   FF_HI   = (ACC_W+1)'(32'h7fff_ffff);
    localparam logic signed [ACC_W:0]   FF_LO   = -FF_HI - (ACC_W+1)'(1);
    localparam logic signed [TOT_W-1:0] Y_HALF  = TOT_W'(1) <<< (Y_SHIFT - 1);
    localparam logic signed [TOT_W-1:0] Y_HI    = TOT_W'(16'sh7fff);
    localparam logic signed [TOT_W-1:0] Y_LO    = -Y_HI - TOT_W'(1);

    logic signed [31:0]      op_b;
    logic signed [63:0]      prod_reg;
    logic signed [ACC_W-1:0] ff_acc_reg;
    logic signed [ACC_W-1:0] fb_reg;
    logic signed [31:0]      ff_sat_reg;
    logic                    ff_clip_reg;

    logic signed [ACC_W:0]   ff_sum;
    logic signed [ACC_W:0]   ff_shr;
    logic signed [31:0]      ff_sat_next;
    logic                    ff_clip_next;
    logic signed [TOT_W-1:0] tot;
    logic signed [TOT_W-1:0] y_shr;
    logic                    y_clip;

    always_comb
    begin
        unique case (ctrl.phase)
            bqc_pkg::PH_B0:   op_b = 32'(x_in);
            bqc_pkg::PH_B1:   op_b = 32'(hist.x1);
            bqc_pkg::PH_B2:   op_b = 32'(hist.x2);
            bqc_pkg::PH_A1:   op_b = 32'(hist.y1);
            bqc_pkg::PH_A2:   op_b = 32'(hist.y2);
            default:          op_b = ff_sat_reg;
        endcase
    end

    // round the feedforward sum to the guard precision, saturate to 32 bits
    always_comb
    begin
        ff_sum       = (ACC_W+1)'(ff_acc_reg) + FF_HALF;
        ff_shr       = ff_sum >>> FF_SHIFT;
        ff_clip_next = 1'b0;
        if (ff_shr > FF_HI)
        begin
            ff_sat_next  = 32'sh7fff_ffff;
            ff_clip_next = 1'b1;
        end
        else if (ff_shr < FF_LO)
        begin
            ff_sat_next  = -32'sh7fff_ffff - 32'sd1;
            ff_clip_next = 1'b1;
        end
        else
        begin
            ff_sat_next = ff_shr[31:0];
        end
    end

    // gain product minus scaled feedback, rounded to an integer sample and saturated to 16 bits
    always_comb
    begin
        tot    = TOT_W'(prod_reg) - (TOT_W'(fb_reg) <<< bqc_pkg::GUARD_BITS) + Y_HALF;
        y_shr  = tot >>> Y_SHIFT;
        y_clip = 1'b0;
        if (y_shr > Y_HI)
        begin
            y      = 16'sh7fff;
            y_clip = 1'b1;
        end
        else if (y_shr < Y_LO)
        begin
            y      = -16'sh7fff - 16'sd1;
            y_clip = 1'b1;
        end
        else
        begin
            y = y_shr[15:0];
        end
        clip = y_clip | ff_clip_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef * op_b;
        if (ctrl.busy)
        begin
            unique case (ctrl.phase)
                bqc_pkg::PH_B1:
                begin
                    ff_acc_reg <= prod_reg[ACC_W-1:0];
                end
                bqc_pkg::PH_B2, bqc_pkg::PH_A1:
                begin
                    ff_acc_reg <= ff_acc_reg + prod_reg[ACC_W-1:0];
                end
                bqc_pkg::PH_A2:
                begin
                    ff_sat_reg  <= ff_sat_next;
                    ff_clip_reg <= ff_clip_next;
                    fb_reg      <= prod_reg[ACC_W-1:0];
                end
                bqc_pkg::PH_GAIN:
                begin
                    fb_reg <= fb_reg + prod_reg[ACC_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

// ===== sv/biquad_cascade_iir_filter_core.sv =====
// ----------------------------------------------------------------------------
// biquad_cascade_iir_filter_core
// Multichannel cascade of direct form I biquad sections with a coefficient
// table and per-channel section histories held in RAM.
// ----------------------------------------------------------------------------
// After reset the core zeroes the coefficient and history RAMs, with item
// ready low. A sample runs through the active sections one after another on
// a single 32x32 multiplier fed from the one coefficient read port, stepping
// each section through the read, b0, b1, b2, a1, a2, gain and write-back
// phases. The result sits in an output register, so the next item is taken
// while it waits. Samples for channels at or above MAX_CHANNELS are dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module biquad_cascade_iir_filter_core #(
    parameter int MAX_CHANNELS   = 32,
    parameter int MAX_SECTIONS   = 4,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic         clk,
    input  logic         rst_n,
    bqc_stream_if.sink   item,
    bqc_stream_if.source result,
    bqc_stream_if.sink   cfg
);
    localparam int HIST_DEPTH = MAX_CHANNELS * MAX_SECTIONS;
    localparam int HIST_AW    = HIST_DEPTH > 1 ? $clog2(HIST_DEPTH) : 1;
    localparam int COEF_DEPTH = MAX_SECTIONS * bqc_pkg::COEFS_PER_SEC;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int SEC_W      = MAX_SECTIONS > 1 ? $clog2(MAX_SECTIONS) : 1;
    localparam int CLR_DEPTH  = HIST_DEPTH > COEF_DEPTH ? HIST_DEPTH : COEF_DEPTH;
    localparam int CLR_W      = $clog2(CLR_DEPTH);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CLR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [SEC_W-1:0]    sec_reg, sec_next;
    logic [SEC_W-1:0]    last_sec_reg, last_sec_next;
    logic [2:0]          phase_reg, phase_next;
    logic [4:0]          ch_reg, ch_next;
    logic signed [15:0]  x_reg, x_next;
    logic                clip_reg, clip_next;
    logic [2:0]          nsec_reg;
    bqc_pkg::out_item_t  out_reg;
    logic                out_valid_reg;

    bqc_pkg::in_item_t   in_item;
    logic                in_xfer;
    logic                out_free;
    logic [3:0]          n_eff;

    logic                coef_we, coef_re;
    logic [COEF_AW-1:0]  coef_waddr, coef_raddr;
    logic signed [31:0]  coef_wdata, coef_rdata;
    logic                hist_we, hist_re;
    logic [HIST_AW-1:0]  hist_addr, hist_waddr;
    bqc_pkg::hist_word_t hist_wdata, hist_rdata;

    bqc_pkg::mac_ctrl_t  mac_ctrl;
    logic signed [15:0]  mac_y;
    logic                mac_clip;

    assign in_item      = item.payload;
    assign item.ready   = (state_reg == ST_IDLE);
    assign in_xfer      = item.valid && item.ready;
    assign cfg.ready    = 1'b1;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;
    assign out_free     = !out_valid_reg || result.ready;

    always_comb
    begin
        if (nsec_reg == 3'd0)
        begin
            n_eff = 4'd1;
        end
        else if (int'(nsec_reg) > MAX_SECTIONS)
        begin
            n_eff = 4'(MAX_SECTIONS);
        end
        else
        begin
            n_eff = {1'b0, nsec_reg};
        end
    end

    // coefficient ram: zeroed by the clear sweep, loaded by write items
    always_comb
    begin
        coef_we    = 1'b0;
        coef_waddr = COEF_AW'(clr_cnt_reg);
        coef_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            coef_we = (int'(clr_cnt_reg) < COEF_DEPTH);
        end
        else if (in_xfer && in_item.cmd == bqc_pkg::CMD_COEF
                 && int'(in_item.coef_slot) < COEF_DEPTH)
        begin
            coef_we    = 1'b1;
            coef_waddr = COEF_AW'(in_item.coef_slot);
            coef_wdata = in_item.coef_word;
        end
        coef_re    = (state_reg == ST_RUN) && (phase_reg <= bqc_pkg::PH_A2);
        coef_raddr = COEF_AW'(int'(sec_reg) * bqc_pkg::COEFS_PER_SEC + int'(phase_reg));
    end

    // history ram: read at the start of a section, written back at its end
    always_comb
    begin
        hist_addr  = HIST_AW'(int'(ch_reg) * MAX_SECTIONS + int'(sec_reg));
        hist_re    = (state_reg == ST_RUN) && (phase_reg == bqc_pkg::PH_READ);
        hist_we    = 1'b0;
        hist_waddr = hist_addr;
        hist_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            hist_we    = (int'(clr_cnt_reg) < HIST_DEPTH);
            hist_waddr = HIST_AW'(clr_cnt_reg);
        end
        else if (state_reg == ST_RUN && phase_reg == bqc_pkg::PH_WB)
        begin
            hist_we       = 1'b1;
            hist_wdata.x1 = x_reg;
            hist_wdata.x2 = hist_rdata.x1;
            hist_wdata.y1 = mac_y;
            hist_wdata.y2 = hist_rdata.y1;
        end
    end

    assign mac_ctrl.busy  = (state_reg == ST_RUN);
    assign mac_ctrl.phase = phase_reg;

    bqc_ram #(
        .WIDTH (32),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .re    (coef_re),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    bqc_ram #(
        .WIDTH ($bits(bqc_pkg::hist_word_t)),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (hist_addr),
        .rdata (hist_rdata)
    );

    bqc_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .coef (coef_rdata),
        .hist (hist_rdata),
        .x_in (x_reg),
        .y    (mac_y),
        .clip (mac_clip)
    );

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        sec_next      = sec_reg;
        last_sec_next = last_sec_reg;
        phase_next    = phase_reg;
        ch_next       = ch_reg;
        x_next        = x_reg;
        clip_next     = clip_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                if (int'(clr_cnt_reg) == CLR_DEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer && in_item.cmd == bqc_pkg::CMD_FILTER
                    && int'(in_item.channel) < MAX_CHANNELS)
                begin
                    state_next    = ST_RUN;
                    ch_next       = in_item.channel;
                    x_next        = in_item.sample_in;
                    clip_next     = 1'b0;
                    sec_next      = '0;
                    phase_next    = bqc_pkg::PH_READ;
                    last_sec_next = SEC_W'(n_eff - 4'd1);
                end
            end
            ST_RUN:
            begin
                phase_next = phase_reg + 3'd1;
                if (phase_reg == bqc_pkg::PH_WB)
                begin
                    x_next    = mac_y;
                    clip_next = clip_reg | mac_clip;
                    sec_next  = sec_reg + SEC_W'(1);
                    if (sec_reg == last_sec_reg)
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            default:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            sec_reg       <= '0;
            last_sec_reg  <= '0;
            phase_reg     <= bqc_pkg::PH_READ;
            nsec_reg      <= 3'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            sec_reg      <= sec_next;
            last_sec_reg <= last_sec_next;
            phase_reg    <= phase_next;
            if (cfg.valid && cfg.ready)
            begin
                nsec_reg <= cfg.payload;
            end
            if (state_reg == ST_HOLD && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        x_reg    <= x_next;
        clip_reg <= clip_next;
        if (state_reg == ST_HOLD && out_free)
        begin
            out_reg.out_channel <= ch_reg;
            out_reg.filtered    <= x_reg;
            out_reg.clipped     <= clip_reg;
        end
    end

    `BQC_ASSERT(a_hist_write_slot, hist_we |-> (state_reg == ST_CLEAR) || (state_reg == ST_RUN && phase_reg == bqc_pkg::PH_WB), "history write outside clear or write-back")
    `BQC_ASSERT(a_sec_bound, (state_reg == ST_RUN) |-> (sec_reg <= last_sec_reg), "section index beyond last active section")
    `BQC_ASSERT(a_result_after_hold, $rose(out_valid_reg) |-> ($past(state_reg) == ST_HOLD), "result raised without a finished sample")
    `BQC_ASSERT(a_coef_write_idle, coef_we |-> (state_reg != ST_RUN), "coefficient write during a sample")
endmodule
